/* design/bemf_zero_cross_commutation_timer_macros.svh */
// Assertion helpers shared by the zero-cross commutation timer
`ifndef BEMF_ZERO_CROSS_COMMUTATION_TIMER_MACROS_SVH
`define BEMF_ZERO_CROSS_COMMUTATION_TIMER_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define BZC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication
`define BZC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BZC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/bzc_pkg.sv */
package bzc_pkg;

    // Field widths
    localparam int TIME_W   = 16;
    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = 19;
    localparam int DIV_W    = 17;

    // Sixty-degree time store
    localparam int SIX_DEPTH = 6;
    localparam int SIX_AW    = 3;

    // Divide by three: floor(x * 43691 / 2^17) is exact for x below 2^17
    localparam logic [15:0] RECIP_DIV3 = 16'd43691;
    localparam int          DIV3_SHIFT = 17;

    // Configuration register indexes
    localparam logic [2:0] CFG_FILTER_DELAY = 3'd0;
    localparam logic [2:0] CFG_PROC_LOW     = 3'd1;
    localparam logic [2:0] CFG_PROC_HIGH    = 3'd2;
    localparam logic [2:0] CFG_ADVANCE      = 3'd3;

    // Detection sequence codes
    localparam logic [3:0] DS_A_FALL       = 4'd0;
    localparam logic [3:0] DS_C_RISE       = 4'd1;
    localparam logic [3:0] DS_B_FALL       = 4'd2;
    localparam logic [3:0] DS_A_RISE       = 4'd3;
    localparam logic [3:0] DS_C_FALL       = 4'd4;
    localparam logic [3:0] DS_B_RISE       = 4'd5;
    localparam logic [3:0] DS_HS_WAIT_FALL = 4'd6;
    localparam logic [3:0] DS_HS_A_FALL    = 4'd7;
    localparam logic [3:0] DS_HS_WAIT_RISE = 4'd8;
    localparam logic [3:0] DS_HS_A_RISE    = 4'd9;

    // Sectors used by the high-speed sequence
    localparam logic [2:0] SECTOR_ARM_FALL   = 3'd2;
    localparam logic [2:0] SECTOR_ARM_RISE   = 3'd5;
    localparam logic [2:0] SECTOR_AFTER_FALL = 3'd4;
    localparam logic [2:0] SECTOR_AFTER_RISE = 3'd1;
    localparam logic [2:0] SECTOR_BACK_LOW   = 3'd0;

    // Sector to drive after each low-speed crossing
    localparam logic [2:0] NEXT_SECTOR_LOW [SIX_DEPTH] =
        '{3'd3, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2};

    // Mode change codes
    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_ENTER_HS = 2'd1;
    localparam logic [1:0] MODE_EXIT_HS  = 2'd2;

    // Request from the sequencer to the time store
    typedef struct packed {
        logic              rd_en;
        logic              six_we;
        logic              ring_we;
        logic [SIX_AW-1:0] six_addr;
        logic [TIME_W-1:0] wdata;
    } store_req_t;

endpackage

/* design/bzc_neutral.sv */
module bzc_neutral #(
    parameter int OFFSET_SHIFT = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [bzc_pkg::SAMPLE_W-1:0]  pa,
    input  logic [bzc_pkg::SAMPLE_W-1:0]  bus,
    output logic signed [15:0]            neutral
);

    logic [31:0] integ_reg;
    logic [31:0] integ_next;
    logic [15:0] shifted;

    // Offset from the integrator, arithmetic shift, kept to 16 bits
    assign shifted = 16'($signed(integ_reg) >>> OFFSET_SHIFT);
    assign neutral = $signed(16'({7'b0, bus[bzc_pkg::SAMPLE_W-1:1]}) + shifted);

    // Accumulate phase A minus the neutral
    assign integ_next = integ_reg + {22'b0, pa} - {{16{neutral[15]}}, neutral};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (step)
        begin
            integ_reg <= integ_next;
        end
    end

endmodule

/* design/bzc_div3.sv */
module bzc_div3 (
    input  logic                       clk,
    input  logic                       load,
    input  logic [bzc_pkg::DIV_W-1:0]  operand,
    output logic [15:0]                quotient
);

    localparam int PROD_W = bzc_pkg::DIV_W + 16;

    logic [PROD_W-1:0] prod_reg;

    // Multiply by the reciprocal of three, register the product
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_W'(operand) * PROD_W'(bzc_pkg::RECIP_DIV3);
        end
    end

    assign quotient = prod_reg[bzc_pkg::DIV3_SHIFT +: 16];

endmodule

/* design/bzc_store.sv */
module bzc_store #(
    parameter int RING_DEPTH = 16,
    localparam int RING_W = $clog2(RING_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bzc_pkg::store_req_t         req,
    input  logic [RING_W-1:0]           ring_waddr,
    input  logic [RING_W-1:0]           ring_raddr,
    output logic [bzc_pkg::TIME_W-1:0]  six_rdata,
    output logic [bzc_pkg::TIME_W-1:0]  ring_rdata
);

    logic [bzc_pkg::TIME_W-1:0] six_mem  [bzc_pkg::SIX_DEPTH];
    logic [bzc_pkg::TIME_W-1:0] ring_mem [RING_DEPTH];

    logic [bzc_pkg::SIX_DEPTH-1:0] six_vld_reg;
    logic [RING_DEPTH-1:0]         ring_vld_reg;
    logic [bzc_pkg::TIME_W-1:0]    six_q_reg;
    logic [bzc_pkg::TIME_W-1:0]    ring_q_reg;
    logic                          six_qv_reg;
    logic                          ring_qv_reg;
    logic                          six_in_range;

    assign six_in_range = (req.six_addr < bzc_pkg::SIX_AW'(bzc_pkg::SIX_DEPTH));

    // Write ports and registered reads
    always_ff @(posedge clk)
    begin
        if (req.six_we && six_in_range)
        begin
            six_mem[req.six_addr] <= req.wdata;
        end
        if (req.ring_we)
        begin
            ring_mem[ring_waddr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            six_q_reg  <= six_in_range ? six_mem[req.six_addr] : '0;
            ring_q_reg <= ring_mem[ring_raddr];
        end
    end

    // Track written entries; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            six_vld_reg  <= '0;
            ring_vld_reg <= '0;
            six_qv_reg   <= 1'b0;
            ring_qv_reg  <= 1'b0;
        end
        else
        begin
            if (req.six_we && six_in_range)
            begin
                six_vld_reg[req.six_addr] <= 1'b1;
            end
            if (req.ring_we)
            begin
                ring_vld_reg[ring_waddr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                six_qv_reg  <= six_in_range ? six_vld_reg[req.six_addr] : 1'b0;
                ring_qv_reg <= ring_vld_reg[ring_raddr];
            end
        end
    end

    assign six_rdata  = six_qv_reg  ? six_q_reg  : '0;
    assign ring_rdata = ring_qv_reg ? ring_q_reg : '0;

endmodule

/* design/bemf_zero_cross_commutation_timer.sv */
// Sensorless BLDC commutation timer: each request carries one set of filtered
// back-EMF samples and returns exactly one result with the crossing flag, the
// commutation delay, the next sector, the high-speed period, the mode change
// and the virtual neutral used. A request passes the neutral and evaluation
// steps when no crossing is found, and also the multiply and finish steps on
// a crossing, then waits in the done state until the output register is free.
// The next request is taken only after that, so one request is in flight at a
// time. The time memories have registered reads and the reciprocal multiplier
// that divides by three is registered. in_ready is high only between requests,
// while a finished result may still sit in the output register.
// Memory contents start as zero through per-entry valid bits, so no clearing
// pass follows reset. Configuration writes are always accepted (cfg_ready is
// tied high) and indexes above 3 are ignored.
`include "bemf_zero_cross_commutation_timer_macros.svh"

module bemf_zero_cross_commutation_timer #(
    parameter int RING_DEPTH   = 16,
    parameter int OFFSET_SHIFT = 13
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [9:0]         phase_a_filtered,
    input  logic [9:0]         phase_b_filtered,
    input  logic [9:0]         phase_c_filtered,
    input  logic [9:0]         bus_voltage,
    input  logic [15:0]        elapsed_ticks,
    input  logic [2:0]         present_sector,
    input  logic               want_high_speed,

    output logic               out_valid,
    input  logic               out_ready,
    output logic               crossing_found,
    output logic [15:0]        commutation_delay,
    output logic [2:0]         sector_to_drive,
    output logic [15:0]        sixty_degree_period,
    output logic               period_valid,
    output logic [1:0]         mode_switch,
    output logic signed [15:0] neutral_level
);

    localparam int RING_W = $clog2(RING_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_NEUT = 7'b0000010,
        S_EVAL = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_LOW  = 7'b0010000,
        S_HIGH = 7'b0100000,
        S_DONE = 7'b1000000
    } fsm_t;

    function automatic logic [15:0] sub_sat0(input logic [17:0] a, input logic [17:0] b);
        logic [17:0] diff;
        begin
            diff = a - b;
            return (a > b) ? diff[15:0] : 16'd0;
        end
    endfunction

    // Control and state registers
    fsm_t                         fsm_reg, fsm_next;
    logic [15:0]                  filter_reg, filter_next;
    logic [15:0]                  proc_lo_reg, proc_lo_next;
    logic [15:0]                  proc_hi_reg, proc_hi_next;
    logic [15:0]                  advance_reg, advance_next;
    logic [3:0]                   st_reg, st_next;
    logic [RING_W-1:0]            ptr_reg, ptr_next;
    logic [bzc_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [15:0]                  last_period_reg, last_period_next;
    logic                         out_valid_reg, out_valid_next;

    // Payload registers
    logic [9:0]                   pa_reg, pa_next;
    logic [9:0]                   pb_reg, pb_next;
    logic [9:0]                   pc_reg, pc_next;
    logic [9:0]                   bus_reg, bus_next;
    logic [15:0]                  elapsed_reg, elapsed_next;
    logic [2:0]                   sector_reg, sector_next;
    logic                         hs_req_reg, hs_req_next;
    logic [15:0]                  neutral_reg, neutral_next;
    logic [17:0]                  pd_reg, pd_next;
    logic [16:0]                  turn_reg, turn_next;
    logic [bzc_pkg::DIV_W-1:0]    div_arg_reg, div_arg_next;
    logic                         res_found_reg, res_found_next;
    logic [15:0]                  res_delay_reg, res_delay_next;
    logic [2:0]                   res_sector_reg, res_sector_next;
    logic                         res_pvalid_reg, res_pvalid_next;
    logic [1:0]                   res_mode_reg, res_mode_next;
    logic                         crossing_found_reg, crossing_found_next;
    logic [15:0]                  commutation_delay_reg, commutation_delay_next;
    logic [2:0]                   sector_to_drive_reg, sector_to_drive_next;
    logic [15:0]                  sixty_degree_period_reg, sixty_degree_period_next;
    logic                         period_valid_reg, period_valid_next;
    logic [1:0]                   mode_switch_reg, mode_switch_next;
    logic [15:0]                  neutral_level_reg, neutral_level_next;

    // Datapath wires
    bzc_pkg::store_req_t          store_req;
    logic [15:0]                  six_rdata;
    logic [15:0]                  ring_rdata;
    logic [RING_W-1:0]            ptr_inc;
    logic [RING_W-1:0]            ptr_prev;
    logic signed [15:0]           neutral_w;
    logic                         neut_step;
    logic                         div_load;
    logic [15:0]                  div_quot;
    logic signed [16:0]           neut_x;
    logic signed [16:0]           pa_x, pb_x, pc_x;
    logic                         a_lt, a_gt, b_lt, b_gt, c_lt, c_gt;
    logic                         hit_low;
    logic                         hit_high;
    logic                         is_low;
    logic [bzc_pkg::SUM_W-1:0]    sum_upd;
    logic [16:0]                  turn_sum;
    logic [17:0]                  thirty_w;
    logic [20:0]                  thirty_x6;
    logic [18:0]                  thirty_x2;
    logic [15:0]                  half_turn_w;
    logic [15:0]                  period_lo_w;

    bzc_neutral #(
        .OFFSET_SHIFT (OFFSET_SHIFT)
    ) u_neutral (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (neut_step),
        .pa      (pa_reg),
        .bus     (bus_reg),
        .neutral (neutral_w)
    );

    bzc_div3 u_div3 (
        .clk      (clk),
        .load     (div_load),
        .operand  (div_arg_reg),
        .quotient (div_quot)
    );

    bzc_store #(
        .RING_DEPTH (RING_DEPTH)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (store_req),
        .ring_waddr (ptr_reg),
        .ring_raddr (ptr_prev),
        .six_rdata  (six_rdata),
        .ring_rdata (ring_rdata)
    );

    // Ring pointer neighbors
    assign ptr_inc  = (ptr_reg == RING_W'(RING_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign ptr_prev = (ptr_reg == '0) ? RING_W'(RING_DEPTH - 1) : ptr_reg - 1'b1;

    // Phase comparisons against the registered neutral
    assign neut_x = $signed({neutral_reg[15], neutral_reg});
    assign pa_x   = $signed({7'b0, pa_reg});
    assign pb_x   = $signed({7'b0, pb_reg});
    assign pc_x   = $signed({7'b0, pc_reg});
    assign a_lt   = pa_x < neut_x;
    assign a_gt   = pa_x > neut_x;
    assign b_lt   = pb_x < neut_x;
    assign b_gt   = pb_x > neut_x;
    assign c_lt   = pc_x < neut_x;
    assign c_gt   = pc_x > neut_x;

    assign is_low = (st_reg < bzc_pkg::DS_HS_WAIT_FALL);

    always_comb
    begin
        case (st_reg)
            bzc_pkg::DS_A_FALL: hit_low = a_lt;
            bzc_pkg::DS_C_RISE: hit_low = c_gt;
            bzc_pkg::DS_B_FALL: hit_low = b_lt;
            bzc_pkg::DS_A_RISE: hit_low = a_gt;
            bzc_pkg::DS_C_FALL: hit_low = c_lt;
            bzc_pkg::DS_B_RISE: hit_low = b_gt;
            default:            hit_low = 1'b0;
        endcase
    end

    assign hit_high = (st_reg == bzc_pkg::DS_HS_A_FALL) ? a_lt : a_gt;

    // Running sum of the six sixty-degree times, replace the old entry
    assign sum_upd  = sum_reg - bzc_pkg::SUM_W'(six_rdata) + bzc_pkg::SUM_W'(elapsed_reg);
    assign turn_sum = 17'(elapsed_reg) + 17'(ring_rdata);

    // Thirty-degree time raised to the phase delay
    assign thirty_w    = (18'(div_quot) < pd_reg) ? pd_reg : 18'(div_quot);
    assign thirty_x6   = 21'(thirty_w) * 21'd6;
    assign thirty_x2   = {1'b0, thirty_w} << 1;
    assign half_turn_w = (thirty_x6 > 21'hFFFF) ? 16'hFFFF : thirty_x6[15:0];
    assign period_lo_w = (thirty_x2 > 19'hFFFF) ? 16'hFFFF : thirty_x2[15:0];

    // Sequencer
    always_comb
    begin
        fsm_next                 = fsm_reg;
        filter_next              = filter_reg;
        proc_lo_next             = proc_lo_reg;
        proc_hi_next             = proc_hi_reg;
        advance_next             = advance_reg;
        st_next                  = st_reg;
        ptr_next                 = ptr_reg;
        sum_next                 = sum_reg;
        last_period_next         = last_period_reg;
        out_valid_next           = out_valid_reg && !out_ready;
        pa_next                  = pa_reg;
        pb_next                  = pb_reg;
        pc_next                  = pc_reg;
        bus_next                 = bus_reg;
        elapsed_next             = elapsed_reg;
        sector_next              = sector_reg;
        hs_req_next              = hs_req_reg;
        neutral_next             = neutral_reg;
        pd_next                  = pd_reg;
        turn_next                = turn_reg;
        div_arg_next             = div_arg_reg;
        res_found_next           = res_found_reg;
        res_delay_next           = res_delay_reg;
        res_sector_next          = res_sector_reg;
        res_pvalid_next          = res_pvalid_reg;
        res_mode_next            = res_mode_reg;
        crossing_found_next      = crossing_found_reg;
        commutation_delay_next   = commutation_delay_reg;
        sector_to_drive_next     = sector_to_drive_reg;
        sixty_degree_period_next = sixty_degree_period_reg;
        period_valid_next        = period_valid_reg;
        mode_switch_next         = mode_switch_reg;
        neutral_level_next       = neutral_level_reg;
        store_req                = '0;
        neut_step                = 1'b0;
        div_load                 = 1'b0;

        // Configuration writes
        if (cfg_valid)
        begin
            case (cfg_index)
                bzc_pkg::CFG_FILTER_DELAY: filter_next  = cfg_data;
                bzc_pkg::CFG_PROC_LOW:     proc_lo_next = cfg_data;
                bzc_pkg::CFG_PROC_HIGH:    proc_hi_next = cfg_data;
                bzc_pkg::CFG_ADVANCE:      advance_next = cfg_data;
                default:                   ;
            endcase
        end

        case (fsm_reg)
            // Capture the request
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pa_next      = phase_a_filtered;
                    pb_next      = phase_b_filtered;
                    pc_next      = phase_c_filtered;
                    bus_next     = bus_voltage;
                    elapsed_next = elapsed_ticks;
                    sector_next  = present_sector;
                    hs_req_next  = want_high_speed;
                    fsm_next     = S_NEUT;
                end
            end

            // Form the neutral, step the integrator, read the stored times
            S_NEUT:
            begin
                neutral_next = neutral_w;
                neut_step    = 1'b1;
                pd_next      = 18'(filter_reg) + 18'(advance_reg)
                             + 18'(is_low ? proc_lo_reg : proc_hi_reg);
                store_req.rd_en    = 1'b1;
                store_req.six_addr = st_reg[bzc_pkg::SIX_AW-1:0];
                fsm_next     = S_EVAL;
            end

            // Look for the crossing of the current state, or arm a high-speed watch on its sector
            S_EVAL:
            begin
                res_found_next  = 1'b0;
                res_delay_next  = '0;
                res_sector_next = '0;
                res_pvalid_next = 1'b0;
                res_mode_next   = bzc_pkg::MODE_NONE;
                fsm_next        = S_DONE;
                if (is_low)
                begin
                    if (hit_low)
                    begin
                        sum_next           = sum_upd;
                        store_req.six_we   = 1'b1;
                        store_req.six_addr = st_reg[bzc_pkg::SIX_AW-1:0];
                        store_req.wdata    = elapsed_reg;
                        div_arg_next       = sum_upd[bzc_pkg::SUM_W-1:2];
                        fsm_next           = S_MUL;
                    end
                end
                else if (st_reg == bzc_pkg::DS_HS_WAIT_FALL)
                begin
                    if (sector_reg == bzc_pkg::SECTOR_ARM_FALL)
                    begin
                        st_next = bzc_pkg::DS_HS_A_FALL;
                    end
                end
                else if (st_reg == bzc_pkg::DS_HS_WAIT_RISE)
                begin
                    if (sector_reg == bzc_pkg::SECTOR_ARM_RISE)
                    begin
                        st_next = bzc_pkg::DS_HS_A_RISE;
                    end
                end
                else if (st_reg == bzc_pkg::DS_HS_A_FALL || st_reg == bzc_pkg::DS_HS_A_RISE)
                begin
                    if (hit_high)
                    begin
                        turn_next         = turn_sum;
                        store_req.ring_we = 1'b1;
                        store_req.wdata   = elapsed_reg;
                        ptr_next          = ptr_inc;
                        div_arg_next      = {1'b0, turn_sum[16:1]};
                        fsm_next          = S_MUL;
                    end
                end
                else
                begin
                    st_next = bzc_pkg::DS_A_FALL;
                end
            end

            // Multiply by the reciprocal of three
            S_MUL:
            begin
                div_load = 1'b1;
                fsm_next = is_low ? S_LOW : S_HIGH;
            end

            // Finish a low-speed crossing
            S_LOW:
            begin
                res_found_next  = 1'b1;
                res_delay_next  = sub_sat0(18'(div_quot), pd_reg);
                res_sector_next = bzc_pkg::NEXT_SECTOR_LOW[st_reg[bzc_pkg::SIX_AW-1:0]];
                store_req.ring_we = 1'b1;
                store_req.wdata   = half_turn_w;
                ptr_next          = ptr_inc;
                if (st_reg == bzc_pkg::DS_A_RISE && hs_req_reg)
                begin
                    st_next          = bzc_pkg::DS_HS_WAIT_FALL;
                    last_period_next = period_lo_w;
                    res_pvalid_next  = 1'b1;
                    res_mode_next    = bzc_pkg::MODE_ENTER_HS;
                end
                else if (st_reg == bzc_pkg::DS_B_RISE)
                begin
                    st_next = bzc_pkg::DS_A_FALL;
                end
                else
                begin
                    st_next = st_reg + 4'd1;
                end
                fsm_next = S_DONE;
            end

            // Finish a high-speed crossing
            S_HIGH:
            begin
                res_found_next   = 1'b1;
                res_pvalid_next  = 1'b1;
                last_period_next = div_quot;
                res_delay_next   = sub_sat0(18'(turn_reg[16:2]), pd_reg);
                if (st_reg == bzc_pkg::DS_HS_A_FALL)
                begin
                    res_sector_next = bzc_pkg::SECTOR_AFTER_FALL;
                    st_next         = bzc_pkg::DS_HS_WAIT_RISE;
                end
                else if (hs_req_reg)
                begin
                    res_sector_next = bzc_pkg::SECTOR_AFTER_RISE;
                    st_next         = bzc_pkg::DS_HS_WAIT_FALL;
                end
                else
                begin
                    res_sector_next = bzc_pkg::SECTOR_BACK_LOW;
                    st_next         = bzc_pkg::DS_C_FALL;
                    res_delay_next  = sub_sat0(18'(div_quot[15:1]), pd_reg);
                    res_mode_next   = bzc_pkg::MODE_EXIT_HS;
                end
                fsm_next = S_DONE;
            end

            // Hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    crossing_found_next      = res_found_reg;
                    commutation_delay_next   = res_delay_reg;
                    sector_to_drive_next     = res_sector_reg;
                    sixty_degree_period_next = last_period_reg;
                    period_valid_next        = res_pvalid_reg;
                    mode_switch_next         = res_mode_reg;
                    neutral_level_next       = neutral_reg;
                    out_valid_next           = 1'b1;
                    fsm_next                 = S_IDLE;
                end
            end

            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg         <= S_IDLE;
            filter_reg      <= '0;
            proc_lo_reg     <= '0;
            proc_hi_reg     <= '0;
            advance_reg     <= '0;
            st_reg          <= bzc_pkg::DS_A_FALL;
            ptr_reg         <= '0;
            sum_reg         <= '0;
            last_period_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            fsm_reg         <= fsm_next;
            filter_reg      <= filter_next;
            proc_lo_reg     <= proc_lo_next;
            proc_hi_reg     <= proc_hi_next;
            advance_reg     <= advance_next;
            st_reg          <= st_next;
            ptr_reg         <= ptr_next;
            sum_reg         <= sum_next;
            last_period_reg <= last_period_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        pa_reg                  <= pa_next;
        pb_reg                  <= pb_next;
        pc_reg                  <= pc_next;
        bus_reg                 <= bus_next;
        elapsed_reg             <= elapsed_next;
        sector_reg              <= sector_next;
        hs_req_reg              <= hs_req_next;
        neutral_reg             <= neutral_next;
        pd_reg                  <= pd_next;
        turn_reg                <= turn_next;
        div_arg_reg             <= div_arg_next;
        res_found_reg           <= res_found_next;
        res_delay_reg           <= res_delay_next;
        res_sector_reg          <= res_sector_next;
        res_pvalid_reg          <= res_pvalid_next;
        res_mode_reg            <= res_mode_next;
        crossing_found_reg      <= crossing_found_next;
        commutation_delay_reg   <= commutation_delay_next;
        sector_to_drive_reg     <= sector_to_drive_next;
        sixty_degree_period_reg <= sixty_degree_period_next;
        period_valid_reg        <= period_valid_next;
        mode_switch_reg         <= mode_switch_next;
        neutral_level_reg       <= neutral_level_next;
    end

    // Ports
    assign cfg_ready           = 1'b1;
    assign in_ready            = (fsm_reg == S_IDLE);
    assign out_valid           = out_valid_reg;
    assign crossing_found      = crossing_found_reg;
    assign commutation_delay   = commutation_delay_reg;
    assign sector_to_drive     = sector_to_drive_reg;
    assign sixty_degree_period = sixty_degree_period_reg;
    assign period_valid        = period_valid_reg;
    assign mode_switch         = mode_switch_reg;
    assign neutral_level       = $signed(neutral_level_reg);

    // Checks
    `BZC_ASSERT_ALWAYS(a_detect_state_range, st_reg <= bzc_pkg::DS_HS_A_RISE,
        "detect state out of range")
    `BZC_ASSERT_IMP(a_quiet_without_crossing, out_valid && !crossing_found,
        commutation_delay == 16'd0 && sector_to_drive == 3'd0,
        "delay or sector set without a crossing")
    `BZC_ASSERT_IMP(a_mode_change_loads_period,
        out_valid && mode_switch != bzc_pkg::MODE_NONE, period_valid,
        "mode change without period load")
    `BZC_ASSERT_NXT(a_one_request_in_flight, in_valid && in_ready, !in_ready,
        "second request taken while busy")

endmodule

/* tb/tb_bemf_zero_cross_commutation_timer.sv */
`timescale 1ns / 100ps

module tb_bemf_zero_cross_commutation_timer;

    localparam int HALF_PERIOD   = 5;
    localparam int RING_N        = 16;
    localparam int OFF_SH        = 13;
    localparam int PHASE_ITEMS   = 245;
    localparam int SETTLE_CYCLES = 8;

    // Sector reached after each low-speed crossing
    localparam logic [2:0] LOW_NEXT [6] = '{3'd3, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2};

    typedef struct packed {
        logic [9:0]  pa;
        logic [9:0]  pb;
        logic [9:0]  pc;
        logic [9:0]  bus;
        logic [15:0] elapsed;
        logic [2:0]  sector;
        logic        hs_req;
    } bemf_sample_t;

    typedef struct packed {
        logic        found;
        logic [15:0] delay;
        logic [2:0]  next_sector;
        logic [15:0] period;
        logic        period_load;
        logic [1:0]  mode;
        logic [15:0] neutral;
    } crossing_t;

    typedef struct packed {
        bemf_sample_t smp;
        logic         typed;
        crossing_t    res;
    } sample_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [9:0]         phase_a_filtered;
    logic [9:0]         phase_b_filtered;
    logic [9:0]         phase_c_filtered;
    logic [9:0]         bus_voltage;
    logic [15:0]        elapsed_ticks;
    logic [2:0]         present_sector;
    logic               want_high_speed;
    logic               out_valid;
    logic               out_ready;
    logic               crossing_found;
    logic [15:0]        commutation_delay;
    logic [2:0]         sector_to_drive;
    logic [15:0]        sixty_degree_period;
    logic               period_valid;
    logic [1:0]         mode_switch;
    logic signed [15:0] neutral_level;

    bemf_zero_cross_commutation_timer #(
        .RING_DEPTH   (RING_N),
        .OFFSET_SHIFT (OFF_SH)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .phase_a_filtered    (phase_a_filtered),
        .phase_b_filtered    (phase_b_filtered),
        .phase_c_filtered    (phase_c_filtered),
        .bus_voltage         (bus_voltage),
        .elapsed_ticks       (elapsed_ticks),
        .present_sector      (present_sector),
        .want_high_speed     (want_high_speed),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .crossing_found      (crossing_found),
        .commutation_delay   (commutation_delay),
        .sector_to_drive     (sector_to_drive),
        .sixty_degree_period (sixty_degree_period),
        .period_valid        (period_valid),
        .mode_switch         (mode_switch),
        .neutral_level       (neutral_level)
    );

    always #HALF_PERIOD clk = ~clk;

    // Shadow copy of the timer state and registers
    logic [15:0] lag_filter;
    logic [15:0] lag_proc_low;
    logic [15:0] lag_proc_high;
    logic [15:0] lag_advance;
    logic [3:0]  seq_state;
    logic [15:0] seg_time [6];
    logic [15:0] half_turn [RING_N];
    int unsigned turn_ptr;
    logic [31:0] offset_acc;
    logic [15:0] held_period;

    crossing_t   pending_results [$];
    sample_row_t dir_rows [$];
    bit          calm;
    int          mismatch_count;
    int          items_sent;
    int          crossings_seen;
    int          hs_entries;
    int          hs_exits;

    function automatic logic [15:0] sat16(input logic [31:0] v);
        return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [31:0] sub_floor0(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a - b : 32'd0;
    endfunction

    // Neutral for a given bus sample, from the integrator as it stands now
    function automatic logic [15:0] neutral_for(input logic [9:0] bus);
        logic signed [31:0] offs;
        logic [31:0]        sum;
        offs = $signed(offset_acc) >>> OFF_SH;
        sum  = 32'(bus >> 1) + 32'(offs);
        return sum[15:0];
    endfunction

    // Advance the shadow state by one sample set and form its result
    function automatic void predict_crossing(input bemf_sample_t s, output crossing_t r);
        logic [15:0] nl;
        int          n_i;
        int          pa_i;
        int          pb_i;
        int          pc_i;
        logic [31:0] pd;
        logic [31:0] thirty;
        logic [31:0] turn;
        logic [31:0] sum6;
        logic [3:0]  st;
        int unsigned p;
        int unsigned q;
        bit          hit;
        r    = '0;
        hit  = 1'b0;
        st   = seq_state;
        pa_i = int'(s.pa);
        pb_i = int'(s.pb);
        pc_i = int'(s.pc);
        nl   = neutral_for(s.bus);
        n_i  = int'($signed(nl));
        offset_acc = offset_acc + 32'(pa_i - n_i);
        pd = 32'(lag_filter) + 32'(lag_advance) +
             32'((st <= bzc_pkg::DS_B_RISE) ? lag_proc_low : lag_proc_high);

        if (st <= bzc_pkg::DS_B_RISE)
        begin
            case (st)
                bzc_pkg::DS_A_FALL: hit = pa_i < n_i;
                bzc_pkg::DS_C_RISE: hit = pc_i > n_i;
                bzc_pkg::DS_B_FALL: hit = pb_i < n_i;
                bzc_pkg::DS_A_RISE: hit = pa_i > n_i;
                bzc_pkg::DS_C_FALL: hit = pc_i < n_i;
                default:            hit = pb_i > n_i;
            endcase
            if (hit)
            begin
                seg_time[st] = s.elapsed;
                sum6 = 32'd0;
                foreach (seg_time[i]) sum6 = sum6 + 32'(seg_time[i]);
                thirty = sum6 / 12;
                if (thirty < pd) thirty = pd;
                r.delay       = 16'(thirty - pd);
                r.next_sector = LOW_NEXT[st];
                r.found       = 1'b1;
                half_turn[turn_ptr] = sat16(thirty * 6);
                turn_ptr = (turn_ptr + 1) % RING_N;
                st = (st == bzc_pkg::DS_B_RISE) ? bzc_pkg::DS_A_FALL : 4'(st + 1);
                // Enter high speed on the rising A crossing when requested
                if (st == bzc_pkg::DS_C_FALL && s.hs_req)
                begin
                    st            = bzc_pkg::DS_HS_WAIT_FALL;
                    held_period   = sat16(thirty * 2);
                    r.period_load = 1'b1;
                    r.mode        = bzc_pkg::MODE_ENTER_HS;
                end
            end
        end
        else if (st == bzc_pkg::DS_HS_WAIT_FALL)
        begin
            if (s.sector == bzc_pkg::SECTOR_ARM_FALL) st = bzc_pkg::DS_HS_A_FALL;
        end
        else if (st == bzc_pkg::DS_HS_WAIT_RISE)
        begin
            if (s.sector == bzc_pkg::SECTOR_ARM_RISE) st = bzc_pkg::DS_HS_A_RISE;
        end
        else if (st == bzc_pkg::DS_HS_A_FALL || st == bzc_pkg::DS_HS_A_RISE)
        begin
            hit = (st == bzc_pkg::DS_HS_A_FALL) ? (pa_i < n_i) : (pa_i > n_i);
            if (hit)
            begin
                p = turn_ptr;
                q = (p + RING_N - 1) % RING_N;
                half_turn[p]  = s.elapsed;
                turn          = 32'(half_turn[p]) + 32'(half_turn[q]);
                held_period   = 16'(turn / 6);
                r.period_load = 1'b1;
                r.delay       = 16'(sub_floor0(turn >> 2, pd));
                turn_ptr      = (p + 1) % RING_N;
                r.found       = 1'b1;
                if (st == bzc_pkg::DS_HS_A_FALL)
                begin
                    r.next_sector = bzc_pkg::SECTOR_AFTER_FALL;
                    st            = bzc_pkg::DS_HS_WAIT_RISE;
                end
                else if (s.hs_req)
                begin
                    r.next_sector = bzc_pkg::SECTOR_AFTER_RISE;
                    st            = bzc_pkg::DS_HS_WAIT_FALL;
                end
                else
                begin
                    // Drop back to low speed
                    r.next_sector = bzc_pkg::SECTOR_BACK_LOW;
                    st            = bzc_pkg::DS_C_FALL;
                    r.delay       = 16'(sub_floor0(32'(held_period >> 1), pd));
                    r.mode        = bzc_pkg::MODE_EXIT_HS;
                end
            end
        end
        else
        begin
            st = bzc_pkg::DS_A_FALL;
        end
        seq_state = st;
        r.period  = held_period;
        r.neutral = nl;
    endfunction

    // Random sample set, mostly steered so the sequence keeps moving
    function automatic void pick_sample(output bemf_sample_t s);
        logic [15:0] nl;
        int          n_i;
        int          v;
        bit          steer_a;
        bit          steer_b;
        bit          steer_c;
        bit          below;
        bit          ok;
        steer_a  = 1'b0;
        steer_b  = 1'b0;
        steer_c  = 1'b0;
        below    = 1'b0;
        ok       = 1'b0;
        v        = 0;
        s.pa     = 10'($urandom_range(0, 1023));
        s.pb     = 10'($urandom_range(0, 1023));
        s.pc     = 10'($urandom_range(0, 1023));
        s.bus    = 10'($urandom_range(0, 1023));
        s.sector = 3'($urandom_range(0, 5));
        s.hs_req = 1'($urandom_range(0, 1));
        s.elapsed = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(0, 4000));
        if ($urandom_range(0, 9) < 2) return;

        nl  = neutral_for(s.bus);
        n_i = int'($signed(nl));
        case (seq_state)
            bzc_pkg::DS_A_FALL:
            begin
                steer_a = 1'b1;
                below   = 1'b1;
            end
            bzc_pkg::DS_C_RISE:       steer_c = 1'b1;
            bzc_pkg::DS_B_FALL:
            begin
                steer_b = 1'b1;
                below   = 1'b1;
            end
            bzc_pkg::DS_A_RISE:       steer_a = 1'b1;
            bzc_pkg::DS_C_FALL:
            begin
                steer_c = 1'b1;
                below   = 1'b1;
            end
            bzc_pkg::DS_B_RISE:       steer_b = 1'b1;
            bzc_pkg::DS_HS_WAIT_FALL:
                if ($urandom_range(0, 1)) s.sector = bzc_pkg::SECTOR_ARM_FALL;
            bzc_pkg::DS_HS_A_FALL:
            begin
                steer_a = 1'b1;
                below   = 1'b1;
            end
            bzc_pkg::DS_HS_WAIT_RISE:
                if ($urandom_range(0, 1)) s.sector = bzc_pkg::SECTOR_ARM_RISE;
            bzc_pkg::DS_HS_A_RISE:
            begin
                steer_a  = 1'b1;
                s.hs_req = ($urandom_range(0, 3) != 0);
            end
            default: ;
        endcase

        if (below)
        begin
            if (n_i > 0)
            begin
                v  = $urandom_range(0, (n_i > 1023) ? 1023 : n_i - 1);
                ok = 1'b1;
            end
        end
        else if (n_i < 1023)
        begin
            v  = $urandom_range((n_i < 0) ? 0 : n_i + 1, 1023);
            ok = 1'b1;
        end
        if (ok)
        begin
            if (steer_a) s.pa = 10'(v);
            if (steer_b) s.pb = 10'(v);
            if (steer_c) s.pc = 10'(v);
        end
    endfunction

    function automatic void add_row(input int pa, input int pb, input int pc, input int bus,
                                    input int el, input int sec, input int hs);
        sample_row_t row;
        row = '0;
        row.smp.pa      = 10'(pa);
        row.smp.pb      = 10'(pb);
        row.smp.pc      = 10'(pc);
        row.smp.bus     = 10'(bus);
        row.smp.elapsed = 16'(el);
        row.smp.sector  = 3'(sec);
        row.smp.hs_req  = 1'(hs);
        dir_rows.push_back(row);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Offer one request, hold it until taken, then record what it should produce
    task automatic send_sample(input bemf_sample_t s, input logic typed, input crossing_t typed_res);
        crossing_t want;
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid         = 1'b1;
        phase_a_filtered = s.pa;
        phase_b_filtered = s.pb;
        phase_c_filtered = s.pc;
        bus_voltage      = s.bus;
        elapsed_ticks    = s.elapsed;
        present_sector   = s.sector;
        want_high_speed  = s.hs_req;
        do @(posedge clk); while (!in_ready);
        predict_crossing(s, want);
        if (typed) want = typed_res;
        pending_results.push_back(want);
        items_sent++;
        if (want.found) crossings_seen++;
        if (want.mode == bzc_pkg::MODE_ENTER_HS) hs_entries++;
        if (want.mode == bzc_pkg::MODE_EXIT_HS) hs_exits++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            bzc_pkg::CFG_FILTER_DELAY: lag_filter    = val;
            bzc_pkg::CFG_PROC_LOW:     lag_proc_low  = val;
            bzc_pkg::CFG_PROC_HIGH:    lag_proc_high = val;
            bzc_pkg::CFG_ADVANCE:      lag_advance   = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] f, input logic [15:0] lo,
                                  input logic [15:0] hi, input logic [15:0] adv);
        write_reg(bzc_pkg::CFG_FILTER_DELAY, f);
        write_reg(bzc_pkg::CFG_PROC_LOW, lo);
        write_reg(bzc_pkg::CFG_PROC_HIGH, hi);
        write_reg(bzc_pkg::CFG_ADVANCE, adv);
    endtask

    // Stop offering requests and let every pending result come out
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: random stall bursts, none in the calm stretch
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    // Compare each result taken against the oldest pending one
    always @(posedge clk)
    begin : result_check
        crossing_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t mismatch: result with nothing pending, delay %0d neutral %0d",
                         $time, commutation_delay, neutral_level);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("crossing_found", int'(want.found), int'(crossing_found));
                check_field("commutation_delay", int'(want.delay), int'(commutation_delay));
                check_field("sector_to_drive", int'(want.next_sector), int'(sector_to_drive));
                check_field("sixty_degree_period", int'(want.period),
                            int'(sixty_degree_period));
                check_field("period_valid", int'(want.period_load), int'(period_valid));
                check_field("mode_switch", int'(want.mode), int'(mode_switch));
                check_field("neutral_level", int'($signed(want.neutral)), int'(neutral_level));
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("bemf_zero_cross_commutation_timer regression: fail");
        $finish;
    end

    initial
    begin
        bemf_sample_t smp;
        crossing_t    typed_res;
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        phase_a_filtered = '0;
        phase_b_filtered = '0;
        phase_c_filtered = '0;
        bus_voltage      = '0;
        elapsed_ticks    = '0;
        present_sector   = '0;
        want_high_speed  = 1'b0;
        calm             = 1'b0;
        mismatch_count   = 0;
        items_sent       = 0;
        crossings_seen   = 0;
        hs_entries       = 0;
        hs_exits         = 0;
        lag_filter       = '0;
        lag_proc_low     = '0;
        lag_proc_high    = '0;
        lag_advance      = '0;
        seq_state        = bzc_pkg::DS_A_FALL;
        turn_ptr         = 0;
        offset_acc       = '0;
        held_period      = '0;
        foreach (seg_time[i]) seg_time[i] = '0;
        foreach (half_turn[i]) half_turn[i] = '0;

        // Directed rows: all-zero sample first, then full-scale sample, both typed
        add_row(0, 0, 0, 0, 0, 0, 0);
        typed_res = '0;
        dir_rows[$].typed = 1'b1;
        dir_rows[$].res   = typed_res;
        add_row(1023, 1023, 1023, 1023, 65535, 5, 1);
        typed_res.neutral = 16'd511;
        dir_rows[$].typed = 1'b1;
        dir_rows[$].res   = typed_res;
        // A falls, C rises and pulls the integrator negative
        add_row(0, 512, 512, 1023, 65535, 0, 0);
        add_row(0, 512, 1023, 1023, 0, 1, 0);
        // Negative neutral on a zero bus: B cannot fall below it
        add_row(0, 0, 512, 0, 300, 2, 0);
        add_row(512, 0, 512, 1023, 1000, 2, 0);
        // A rises with the high-speed request set
        add_row(1023, 512, 512, 1023, 12000, 3, 1);
        // High-speed waits, wrong sector first
        add_row(300, 512, 512, 600, 5000, 0, 1);
        add_row(512, 512, 512, 1023, 5000, 2, 1);
        add_row(0, 512, 512, 1023, 30000, 4, 1);
        add_row(512, 512, 512, 1023, 100, 2, 1);
        add_row(512, 512, 512, 1023, 100, 5, 1);
        add_row(1023, 512, 512, 1023, 65535, 3, 1);
        add_row(512, 512, 512, 1023, 0, 2, 1);
        add_row(0, 512, 512, 1023, 0, 1, 1);
        add_row(512, 512, 512, 1023, 0, 5, 0);
        // Rising watch sees a low sample: no crossing
        add_row(0, 512, 512, 1023, 9000, 0, 0);
        // Rising crossing without the request: back to low speed
        add_row(1023, 512, 512, 1023, 20000, 0, 0);
        add_row(512, 512, 0, 1023, 4000, 1, 0);
        add_row(512, 1023, 512, 1023, 8000, 2, 0);
        // Request ignored outside the rising A crossing, and absent there
        add_row(0, 512, 512, 1023, 65535, 3, 1);
        add_row(512, 512, 1023, 1023, 65535, 4, 0);
        add_row(512, 0, 512, 1023, 65535, 5, 0);
        add_row(1023, 512, 512, 1023, 1, 0, 0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i]) send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].res);
        drain_results();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
                1: apply_settings(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                                  16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)));
                2: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3:
                begin
                    apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                    write_reg(3'(bzc_pkg::CFG_ADVANCE + 1 + $urandom_range(0, 3)),
                              16'($urandom_range(0, 65535)));
                end
                default:
                begin
                    apply_settings(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                                   16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)));
                    calm = 1'b1;
                end
            endcase
            repeat (PHASE_ITEMS)
            begin
                pick_sample(smp);
                send_sample(smp, 1'b0, '0);
            end
            drain_results();
        end

        $display("covered %0d sample sets with %0d crossings, %0d high-speed entries, %0d returns",
                 items_sent, crossings_seen, hs_entries, hs_exits);
        $display("registers run at reset, zero, moderate, all-ones, random and small settings");
        if (mismatch_count == 0)
            $display("bemf_zero_cross_commutation_timer regression: pass");
        else
            $display("bemf_zero_cross_commutation_timer regression: fail");
        $finish;
    end

endmodule

/* bemf_zero_cross_commutation_timer.f */
+incdir+design
design/bzc_pkg.sv
design/bzc_neutral.sv
design/bzc_div3.sv
design/bzc_store.sv
design/bemf_zero_cross_commutation_timer.sv
tb/tb_bemf_zero_cross_commutation_timer.sv
